### rtl/olist_pkg.sv
// shared constants, codes and types of the ordered list engine
`default_nettype none

package olist_pkg;

   localparam int CAPACITY = 32;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KIND_W   = 3;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GET    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LAST   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SORT   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      data_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic eq;
      logic after;
   } cmp_res_type;

endpackage

`default_nettype wire

### rtl/ordered_list_engine_core.sv
// top level of the ordered list engine: command sequencer and result register
//
// Keeps a list of up to CAPACITY signed 32-bit values in a single-port-read
// memory and runs one command at a time under a small sequencer. req_tuser
// carries the command kind (append, get, last, dump, remove, sort), req_tdata
// the value, 1-based position and sort direction. Every command gives one
// result transfer, except dump on a non-empty list, which gives one transfer
// per entry in list order with rsp_tlast on the final one; rsp_tuser carries
// the status (ok, empty, not found, full) and rsp_tdata the value read, else
// zero. The one memory read port and the shared compare unit set the pace:
// append writes in the decode step, last and get read the memory and then
// load the result register, dump reads and emits each entry in turn, remove
// scans for the value and then closes the gap, and sort is an insertion sort
// with one compare per cycle, shortest on sorted data, longest on reversed
// data. req_tready is low while a command runs; a finished result
// may wait in the output register while the next command is taken.
`default_nettype none

module ordered_list_engine_core
   import olist_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // command channel
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [39:0]         req_tdata,   // value[31:0], position[38:32], descending[39]
   input  wire logic [KIND_W-1:0]   req_tuser,   // kind[2:0]
   // result channel
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [DATA_W-1:0]        rsp_tdata,   // data[31:0]
   output logic [STATUS_W-1:0]      rsp_tuser,   // status[1:0]
   output logic                     rsp_tlast
);

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_READ_DONE = 4'd2;
   localparam logic [3:0] S_DUMP_RD   = 4'd3;
   localparam logic [3:0] S_DUMP      = 4'd4;
   localparam logic [3:0] S_SCAN      = 4'd5;
   localparam logic [3:0] S_SHIFT     = 4'd6;
   localparam logic [3:0] S_SORT_I    = 4'd7;
   localparam logic [3:0] S_SORT_KEY  = 4'd8;
   localparam logic [3:0] S_SORT_CMP  = 4'd9;
   localparam logic [3:0] S_SORT_PUT  = 4'd10;
   localparam logic [3:0] S_EMIT      = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [3:0]          ret_ff, ret_in;        // where to go after a result is handed over
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    i_ff, i_in;            // walk index (dump, scan, shift, sort outer)
   logic [CNT_W-1:0]    j_ff, j_in;            // insertion slot of the sort
   logic [KIND_W-1:0]   kind_ff, kind_in;
   data_type            opnd_ff, opnd_in;      // append or remove value, then sort key
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                desc_ff, desc_in;

   // pending result, built by the sequencer
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   data_type            res_data_ff, res_data_in;
   logic                res_last_ff, res_last_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   data_type            rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   mem_wr_type          mem_wr;
   logic [IDX_W-1:0]    rd_addr;
   data_type            rd_data;
   cmp_res_type         cmp;

   logic                req_xfer;
   logic                out_free;
   logic                rsp_load;
   logic [POS_W-1:0]    get_idx;
   logic [CNT_W-1:0]    i_p1, i_p2, j_m1, j_m2, cnt_m1;

   // index one below a given walk position
   function automatic logic [IDX_W-1:0] j_m1_of_i(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] d;
      d = v - CNT_W'(1);
      return d[IDX_W-1:0];
   endfunction

   olist_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one compare unit: memory word against the held operand
   olist_cmp u_cmp (
      .a          (rd_data),
      .b          (opnd_ff),
      .descending (desc_ff),
      .res        (cmp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign i_p1    = i_ff + CNT_W'(1);
   assign i_p2    = i_ff + CNT_W'(2);
   assign j_m1    = j_ff - CNT_W'(1);
   assign j_m2    = j_ff - CNT_W'(2);
   assign cnt_m1  = count_ff - CNT_W'(1);
   // position 0 counts as the first entry
   assign get_idx = (pos_ff == '0) ? '0 : pos_ff - POS_W'(1);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      kind_in       = kind_ff;
      opnd_in       = opnd_ff;
      pos_in        = pos_ff;
      desc_in       = desc_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_last_in   = res_last_ff;
      rsp_load      = 1'b0;
      mem_wr.en     = 1'b0;
      mem_wr.addr   = i_ff[IDX_W-1:0];
      mem_wr.data   = rd_data;
      rd_addr       = i_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               kind_in  = req_tuser;
               opnd_in  = data_type'(req_tdata[31:0]);
               pos_in   = req_tdata[38:32];
               desc_in  = req_tdata[39];
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            // single-result commands default to an ok result ending the run
            res_status_in = ST_OK;
            res_data_in   = '0;
            res_last_in   = 1'b1;
            ret_in        = S_IDLE;
            state_in      = S_EMIT;
            if ((kind_ff inside {[KIND_GET:KIND_SORT]}) && (count_ff == '0)) begin
               res_status_in = ST_EMPTY;
            end else begin
               case (kind_ff)
                  KIND_APPEND: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = count_ff[IDX_W-1:0];
                        mem_wr.data = opnd_ff;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_GET: begin
                     if (get_idx >= POS_W'(count_ff)) begin
                        res_status_in = ST_NOT_FOUND;
                     end else begin
                        rd_addr  = get_idx[IDX_W-1:0];
                        state_in = S_READ_DONE;
                     end
                  end
                  KIND_LAST: begin
                     rd_addr  = cnt_m1[IDX_W-1:0];
                     state_in = S_READ_DONE;
                  end
                  KIND_DUMP: begin
                     i_in     = '0;
                     rd_addr  = '0;
                     state_in = S_DUMP;
                  end
                  KIND_REMOVE: begin
                     i_in     = '0;
                     rd_addr  = '0;
                     state_in = S_SCAN;
                  end
                  KIND_SORT: begin
                     i_in     = CNT_W'(1);
                     state_in = S_SORT_I;
                  end
                  default: begin
                     // unused kinds: plain ok result
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_READ_DONE: begin
            res_data_in = rd_data;
            state_in    = S_EMIT;
         end

         S_DUMP_RD: begin
            state_in = S_DUMP;
         end

         S_DUMP: begin
            res_status_in = ST_OK;
            res_data_in   = rd_data;
            res_last_in   = (i_p1 == count_ff);
            ret_in        = (i_p1 == count_ff) ? S_IDLE : S_DUMP_RD;
            i_in          = i_p1;
            state_in      = S_EMIT;
         end

         S_SCAN: begin
            if (cmp.eq) begin
               if (i_p1 == count_ff) begin
                  // match at the tail: nothing to move
                  count_in = cnt_m1;
                  state_in = S_EMIT;
               end else begin
                  rd_addr  = i_p1[IDX_W-1:0];
                  state_in = S_SHIFT;
               end
            end else if (i_p1 == count_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_EMIT;
            end else begin
               rd_addr = i_p1[IDX_W-1:0];
               i_in    = i_p1;
            end
         end

         S_SHIFT: begin
            // close the gap: entry i takes entry i+1
            mem_wr.en   = 1'b1;
            mem_wr.addr = i_ff[IDX_W-1:0];
            mem_wr.data = rd_data;
            if (i_p2 >= count_ff) begin
               count_in = cnt_m1;
               state_in = S_EMIT;
            end else begin
               rd_addr = i_p2[IDX_W-1:0];
               i_in    = i_p1;
            end
         end

         S_SORT_I: begin
            if (i_ff >= count_ff) begin
               state_in = S_EMIT;
            end else begin
               rd_addr  = i_ff[IDX_W-1:0];
               state_in = S_SORT_KEY;
            end
         end

         S_SORT_KEY: begin
            opnd_in  = rd_data;
            j_in     = i_ff;
            rd_addr  = j_m1_of_i(i_ff);
            state_in = S_SORT_CMP;
         end

         S_SORT_CMP: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = j_ff[IDX_W-1:0];
            if (cmp.after) begin
               // move the out-of-order neighbor up one slot
               mem_wr.data = rd_data;
               j_in        = j_m1;
               if (j_m1 == '0) begin
                  state_in = S_SORT_PUT;
               end else begin
                  rd_addr = j_m2[IDX_W-1:0];
               end
            end else begin
               mem_wr.data = opnd_ff;
               i_in        = i_p1;
               state_in    = S_SORT_I;
            end
         end

         S_SORT_PUT: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = j_ff[IDX_W-1:0];
            mem_wr.data = opnd_ff;
            i_in        = i_p1;
            state_in    = S_SORT_I;
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ret_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: a result waits here while the sequencer goes on
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_data_in   = res_data_ff;
         rsp_last_in   = res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      kind_ff       <= kind_in;
      opnd_ff       <= opnd_in;
      pos_ff        <= pos_in;
      desc_ff       <= desc_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // the fill count moves by at most one entry per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == $past(count_ff)) ||
               (count_ff == $past(count_ff) + CNT_W'(1)) ||
               (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("list count jumped by more than one");

   // writes stay inside the filled part of the list, or at its tail on append
   a_wr_in_list: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> (CNT_W'(mem_wr.addr) <= count_ff))
      else $error("memory write beyond the list tail");

   // a full status is only reported while the list is really full
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (res_status_ff == ST_FULL)) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("full status with room left");

   // sorting never changes the number of entries
   a_sort_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SORT_I) || (state_ff == S_SORT_KEY) ||
       (state_ff == S_SORT_CMP) || (state_ff == S_SORT_PUT)) |=> $stable(count_ff))
      else $error("count changed during sort");

endmodule

`default_nettype wire

### rtl/olist_mem.sv
// entry storage: one write port, one read port with registered read data
`default_nettype none

module olist_mem
   import olist_pkg::*;
(
   input  wire logic             clock,
   input  wire mem_wr_type       wr,
   input  wire logic [IDX_W-1:0] rd_addr,
   output data_type              rd_data
);

   data_type entries [CAPACITY];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entries[wr.addr] <= wr.data;
      end
      rd_data_ff <= entries[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/olist_cmp.sv
// shared compare unit: equality for remove, order test for sort
`default_nettype none

module olist_cmp
   import olist_pkg::*;
(
   input  wire data_type  a,
   input  wire data_type  b,
   input  wire logic      descending,
   output cmp_res_type    res
);

   // after: a must be placed behind b in the requested order
   always_comb begin
      res.eq    = (a == b);
      res.after = descending ? (a < b) : (a > b);
   end

endmodule

`default_nettype wire
